### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, quiet while reset is active (active-low reset)
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### hdl/isrs_pkg.sv
// ---------------------------------------------------------------------------
// isrs_pkg
// Shared types and codes of the idle-stop relay sequencer
// ---------------------------------------------------------------------------
package isrs_pkg;

  // pulse timer reload value after reset
  localparam logic [7:0] PULSE_TICKS_RST = 8'd24;

  // pulse counter saturation and reset values
  localparam logic [2:0] COUNT_MAX = 3'd7;
  localparam logic [2:0] COUNT_RST = 3'd4;

  // power-take-off phases
  localparam logic [2:0] PTO_IDLE     = 3'd0;
  localparam logic [2:0] PTO_ENGAGED  = 3'd1;
  localparam logic [2:0] PTO_HELD     = 3'd2;
  localparam logic [2:0] PTO_RELEASE  = 3'd3;
  localparam logic [2:0] PTO_REL_ON   = 3'd4;
  localparam logic [2:0] PTO_REL_OFF  = 3'd5;

  // button sequence steps
  localparam logic [2:0] BTN_IDLE     = 3'd0;
  localparam logic [2:0] BTN_P1_HELD  = 3'd1;
  localparam logic [2:0] BTN_P1_REL   = 3'd2;
  localparam logic [2:0] BTN_P1_OFF   = 3'd3;
  localparam logic [2:0] BTN_WAIT     = 3'd4;
  localparam logic [2:0] BTN_P2_HELD  = 3'd5;
  localparam logic [2:0] BTN_P2_REL   = 3'd6;
  localparam logic [2:0] BTN_P2_OFF   = 3'd7;

  // one result
  typedef struct packed {
    logic       relay_on;
    logic [2:0] sequence_step;
    logic [2:0] pto_phase_out;
  } res_t;

endpackage

### hdl/idle_stop_relay_sequencer_top.sv
// ---------------------------------------------------------------------------
// idle_stop_relay_sequencer_top
// Relay pulse sequencer for idle-stop button and power-take-off signals
// ---------------------------------------------------------------------------
// One request is one sample period (button, power-take-off, base tick). The
// block takes one request per clock while in_ready is high; the whole state
// update (pulse timer, saturating pulse counter, button and power-take-off
// sequences) is combinational and each request yields one registered result.
// A two-entry output buffer (result and skid registers) keeps input flowing
// for one more request while a result waits; after that in_ready drops until
// out_ready frees a slot. cfg_wr_data sets the timer length in base ticks
// (0 means 256); the user writes it only while idle, unchecked by the block.
`include "assert_macros.svh"

module idle_stop_relay_sequencer_top (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // sample requests
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_button_pressed,
  input  logic       in_pto_active,
  input  logic       in_tick,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_relay_on,
  output logic [2:0] out_sequence_step,
  output logic [2:0] out_pto_phase_out
);
  import isrs_pkg::*;

  // configuration and sequencer state
  logic [7:0] pulse_ticks_r;
  logic [2:0] button_step_r, button_step_nxt;
  logic [2:0] pto_phase_r, pto_phase_nxt;
  logic       click_latch_r, click_latch_nxt;
  logic [2:0] pulse_count_r, pulse_count_nxt;
  logic       timer_armed_r, timer_armed_nxt;
  logic [7:0] timer_left_r, timer_left_nxt;
  logic       relay_level_r, relay_level_nxt;

  // output buffer
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r, out_res_nxt;
  logic       skid_valid_r, skid_valid_nxt;
  res_t       skid_res_r, skid_res_nxt;

  logic       in_acc;
  logic       out_take;
  logic [7:0] left_dec;
  res_t       new_res;

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_take = out_valid_r && out_ready;
  assign left_dec = timer_left_r - 8'd1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= PULSE_TICKS_RST;
    end else if (cfg_wr_en) begin
      pulse_ticks_r <= cfg_wr_data;
    end
  end

  // one pass over the rules, each seeing the effects of those before it
  always_comb begin
    button_step_nxt = button_step_r;
    pto_phase_nxt   = pto_phase_r;
    click_latch_nxt = click_latch_r;
    pulse_count_nxt = pulse_count_r;
    timer_armed_nxt = timer_armed_r;
    timer_left_nxt  = timer_left_r;
    relay_level_nxt = relay_level_r;

    // pulse timer
    if (in_tick && timer_armed_r) begin
      timer_left_nxt = left_dec;
      if (left_dec == 8'd0) begin
        timer_armed_nxt = 1'b0;
        if (pulse_count_r < COUNT_MAX) begin
          pulse_count_nxt = pulse_count_r + 3'd1;
        end
      end
    end

    // power-take-off engage
    if (in_pto_active && button_step_nxt == BTN_IDLE && pto_phase_nxt == PTO_IDLE
        && pulse_count_nxt == 3'd4) begin
      relay_level_nxt = 1'b1;
      pulse_count_nxt = 3'd0;
      pto_phase_nxt   = PTO_ENGAGED;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (!in_pto_active && pto_phase_nxt == PTO_ENGAGED) begin
      click_latch_nxt = 1'b1;
    end
    if (button_step_nxt == BTN_IDLE && pto_phase_nxt == PTO_ENGAGED
        && pulse_count_nxt == 3'd1) begin
      relay_level_nxt = 1'b0;
      pto_phase_nxt   = PTO_HELD;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
      if (click_latch_nxt) begin
        pto_phase_nxt   = PTO_RELEASE;
        click_latch_nxt = 1'b0;
      end
    end

    // power-take-off release
    if (!in_pto_active && pto_phase_nxt == PTO_HELD) begin
      pto_phase_nxt = PTO_RELEASE;
    end
    if (button_step_nxt == BTN_IDLE && pto_phase_nxt == PTO_RELEASE
        && pulse_count_nxt == 3'd2) begin
      relay_level_nxt = 1'b1;
      pto_phase_nxt   = PTO_REL_ON;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (button_step_nxt == BTN_IDLE && pto_phase_nxt == PTO_REL_ON
        && pulse_count_nxt == 3'd3) begin
      relay_level_nxt = 1'b0;
      pto_phase_nxt   = PTO_REL_OFF;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (!in_pto_active && pto_phase_nxt == PTO_REL_OFF && pulse_count_nxt == 3'd4) begin
      pto_phase_nxt = PTO_IDLE;
    end

    // button sequence, first pulse
    if (in_button_pressed && button_step_nxt == BTN_IDLE && pulse_count_nxt == 3'd4
        && !click_latch_nxt && pto_phase_nxt == PTO_IDLE) begin
      relay_level_nxt = 1'b1;
      pulse_count_nxt = 3'd0;
      click_latch_nxt = 1'b1;
      button_step_nxt = BTN_P1_HELD;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (!in_button_pressed && button_step_nxt == BTN_P1_HELD && pto_phase_nxt == PTO_IDLE) begin
      button_step_nxt = BTN_P1_REL;
    end
    if (pulse_count_nxt == 3'd1 && button_step_nxt == BTN_P1_REL
        && pto_phase_nxt == PTO_IDLE) begin
      relay_level_nxt = 1'b0;
      click_latch_nxt = 1'b0;
      button_step_nxt = BTN_P1_OFF;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (!in_button_pressed && pulse_count_nxt == 3'd2 && button_step_nxt == BTN_P1_OFF
        && pto_phase_nxt == PTO_IDLE) begin
      button_step_nxt = BTN_WAIT;
    end

    // power-take-off watch while waiting for the second press
    if (in_pto_active && button_step_nxt == BTN_WAIT && pto_phase_nxt == PTO_IDLE) begin
      pto_phase_nxt = PTO_ENGAGED;
    end
    if (!in_pto_active && button_step_nxt == BTN_WAIT && pto_phase_nxt == PTO_ENGAGED) begin
      pto_phase_nxt = PTO_IDLE;
    end

    // button sequence, second pulse
    if (in_button_pressed && button_step_nxt == BTN_WAIT && pulse_count_nxt == 3'd2
        && pto_phase_nxt == PTO_IDLE) begin
      relay_level_nxt = 1'b1;
      button_step_nxt = BTN_P2_HELD;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (!in_button_pressed && button_step_nxt == BTN_P2_HELD && pto_phase_nxt == PTO_IDLE) begin
      button_step_nxt = BTN_P2_REL;
    end
    if (pulse_count_nxt == 3'd3 && button_step_nxt == BTN_P2_REL
        && pto_phase_nxt == PTO_IDLE) begin
      relay_level_nxt = 1'b0;
      button_step_nxt = BTN_P2_OFF;
      timer_armed_nxt = 1'b1;
      timer_left_nxt  = pulse_ticks_r;
    end
    if (!in_button_pressed && pulse_count_nxt == 3'd4 && button_step_nxt == BTN_P2_OFF
        && pto_phase_nxt == PTO_IDLE) begin
      button_step_nxt = BTN_IDLE;
    end
  end

  // sequencer state advances on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_step_r <= BTN_IDLE;
      pto_phase_r   <= PTO_IDLE;
      click_latch_r <= 1'b0;
      pulse_count_r <= COUNT_RST;
      timer_armed_r <= 1'b0;
      timer_left_r  <= 8'd0;
      relay_level_r <= 1'b0;
    end else if (in_acc) begin
      button_step_r <= button_step_nxt;
      pto_phase_r   <= pto_phase_nxt;
      click_latch_r <= click_latch_nxt;
      pulse_count_r <= pulse_count_nxt;
      timer_armed_r <= timer_armed_nxt;
      timer_left_r  <= timer_left_nxt;
      relay_level_r <= relay_level_nxt;
    end
  end

  assign new_res = '{relay_on: relay_level_nxt, sequence_step: button_step_nxt,
                     pto_phase_out: pto_phase_nxt};

  // result register with skid slot
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = new_res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_relay_on      = out_res_r.relay_on;
  assign out_sequence_step = out_res_r.sequence_step;
  assign out_pto_phase_out = out_res_r.pto_phase_out;

  // checks
  `ASSERT_RST(a_acc_gives_result, clk, rst_n, in_acc |=> out_valid_r, "accepted request left no result")
  `ASSERT_RST(a_state_holds_idle, clk, rst_n, !in_acc |=> $stable(relay_level_r) && $stable(pulse_count_r), "state moved without a request")
  `ASSERT_RST(a_phase_range, clk, rst_n, pto_phase_r <= PTO_REL_OFF, "power-take-off phase out of range")
  `ASSERT_RST(a_step_phase, clk, rst_n, button_step_r != BTN_IDLE |-> pto_phase_r <= PTO_ENGAGED, "button sequence overlaps power-take-off release")
  `ASSERT_RST(a_skid_only_full, clk, rst_n, skid_valid_r |-> out_valid_r, "skid slot filled ahead of result register")

endmodule

### tb/tb_idle_stop_relay_sequencer_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_idle_stop_relay_sequencer_top
// Self-checking bench for the idle-stop relay sequencer: a scoreboard
// tracks relay, button step and power-take-off phase per sample request,
// under scripted and random sequences, several timer lengths and
// random idling on both channels
// ---------------------------------------------------------------------------
module tb_idle_stop_relay_sequencer_top;
  import isrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 60;
  localparam int SETTLE_CYCLES  = 4;
  localparam int NUM_PHASES     = 6;
  localparam int MAX_PRINTED    = 40;

  // stimulus styles for the random part
  typedef enum int {STIM_BUTTON, STIM_PTO, STIM_NOISE} stim_style_t;

  // expected relay state per sample request, plus the comparison
  class relay_scoreboard;
    logic [7:0] pulse_ticks;
    logic [2:0] btn_step;
    logic [2:0] pto_ph;
    logic [2:0] pulse_cnt;
    logic       click;
    logic       armed;
    logic [7:0] ticks_left;
    logic       relay;
    res_t       expected_q[$];
    int         accepted;
    int         checked;
    int         mismatches;

    function new();
      pulse_ticks = PULSE_TICKS_RST;
      btn_step    = BTN_IDLE;
      pto_ph      = PTO_IDLE;
      pulse_cnt   = COUNT_RST;
      click       = 1'b0;
      armed       = 1'b0;
      ticks_left  = 8'd0;
      relay       = 1'b0;
      accepted    = 0;
      checked     = 0;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void arm_pulse();
      armed      = 1'b1;
      ticks_left = pulse_ticks;
    endfunction

    // one sample period; every rule sees the rules above it
    function res_t advance_period(bit btn, bit pto, bit tk);
      res_t r;
      // pulse timer, wraps at 8 bits so a zero length runs 256 ticks
      if (tk && armed) begin
        ticks_left = ticks_left - 8'd1;
        if (ticks_left == 8'd0) begin
          armed = 1'b0;
          if (pulse_cnt < COUNT_MAX) pulse_cnt = pulse_cnt + 3'd1;
        end
      end
      // power-take-off engage
      if (pto && btn_step == BTN_IDLE && pto_ph == PTO_IDLE && pulse_cnt == 3'd4) begin
        relay     = 1'b1;
        pulse_cnt = 3'd0;
        pto_ph    = PTO_ENGAGED;
        arm_pulse();
      end
      if (!pto && pto_ph == PTO_ENGAGED) click = 1'b1;
      if (btn_step == BTN_IDLE && pto_ph == PTO_ENGAGED && pulse_cnt == 3'd1) begin
        relay  = 1'b0;
        pto_ph = PTO_HELD;
        arm_pulse();
        if (click) begin
          pto_ph = PTO_RELEASE;
          click  = 1'b0;
        end
      end
      // power-take-off release
      if (!pto && pto_ph == PTO_HELD) pto_ph = PTO_RELEASE;
      if (btn_step == BTN_IDLE && pto_ph == PTO_RELEASE && pulse_cnt == 3'd2) begin
        relay  = 1'b1;
        pto_ph = PTO_REL_ON;
        arm_pulse();
      end
      if (btn_step == BTN_IDLE && pto_ph == PTO_REL_ON && pulse_cnt == 3'd3) begin
        relay  = 1'b0;
        pto_ph = PTO_REL_OFF;
        arm_pulse();
      end
      if (!pto && pto_ph == PTO_REL_OFF && pulse_cnt == 3'd4) pto_ph = PTO_IDLE;
      // button, first pulse
      if (btn && btn_step == BTN_IDLE && pulse_cnt == 3'd4 && !click &&
          pto_ph == PTO_IDLE) begin
        relay     = 1'b1;
        pulse_cnt = 3'd0;
        click     = 1'b1;
        btn_step  = BTN_P1_HELD;
        arm_pulse();
      end
      if (!btn && btn_step == BTN_P1_HELD && pto_ph == PTO_IDLE) btn_step = BTN_P1_REL;
      if (pulse_cnt == 3'd1 && btn_step == BTN_P1_REL && pto_ph == PTO_IDLE) begin
        relay    = 1'b0;
        click    = 1'b0;
        btn_step = BTN_P1_OFF;
        arm_pulse();
      end
      if (!btn && pulse_cnt == 3'd2 && btn_step == BTN_P1_OFF && pto_ph == PTO_IDLE)
        btn_step = BTN_WAIT;
      // power-take-off watch while waiting between pulses
      if (pto && btn_step == BTN_WAIT && pto_ph == PTO_IDLE) pto_ph = PTO_ENGAGED;
      if (!pto && btn_step == BTN_WAIT && pto_ph == PTO_ENGAGED) pto_ph = PTO_IDLE;
      // button, second pulse
      if (btn && btn_step == BTN_WAIT && pulse_cnt == 3'd2 && pto_ph == PTO_IDLE) begin
        relay    = 1'b1;
        btn_step = BTN_P2_HELD;
        arm_pulse();
      end
      if (!btn && btn_step == BTN_P2_HELD && pto_ph == PTO_IDLE) btn_step = BTN_P2_REL;
      if (pulse_cnt == 3'd3 && btn_step == BTN_P2_REL && pto_ph == PTO_IDLE) begin
        relay    = 1'b0;
        btn_step = BTN_P2_OFF;
        arm_pulse();
      end
      if (!btn && pulse_cnt == 3'd4 && btn_step == BTN_P2_OFF && pto_ph == PTO_IDLE)
        btn_step = BTN_IDLE;

      r.relay_on      = relay;
      r.sequence_step = btn_step;
      r.pto_phase_out = pto_ph;
      return r;
    endfunction

    function void note_request(bit btn, bit pto, bit tk);
      expected_q.push_back(advance_period(btn, pto, tk));
      accepted++;
    endfunction

    // prints one line while the count is low, counts always
    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.relay_on !== exp_r.relay_on)
        report_mismatch($sformatf("result %0d relay_on %b, expected %b",
                                  checked, got.relay_on, exp_r.relay_on));
      if (got.sequence_step !== exp_r.sequence_step)
        report_mismatch($sformatf("result %0d sequence_step %0d, expected %0d",
                                  checked, got.sequence_step, exp_r.sequence_step));
      if (got.pto_phase_out !== exp_r.pto_phase_out)
        report_mismatch($sformatf("result %0d pto_phase_out %0d, expected %0d",
                                  checked, got.pto_phase_out, exp_r.pto_phase_out));
    endtask
  endclass

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       cfg_wr_en         = 1'b0;
  logic [7:0] cfg_wr_data       = 8'd0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic       in_button_pressed = 1'b0;
  logic       in_pto_active     = 1'b0;
  logic       in_tick           = 1'b0;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic       out_relay_on;
  logic [2:0] out_sequence_step;
  logic [2:0] out_pto_phase_out;

  relay_scoreboard relay_sb = new();

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_token     = 0;
  int   hold_seen      = 0;
  int   hold_left      = 0;
  int   quiet_cycles   = 0;
  res_t seen_result;

  // scripted part, {button, pto, tick}: idle tick, full button run,
  // held pto run, quick pto click, then leftover combinations
  logic [2:0] scripted [23] = '{
    3'b001, 3'b100, 3'b100, 3'b000, 3'b001, 3'b001, 3'b100, 3'b000,
    3'b001, 3'b001, 3'b010, 3'b011, 3'b000, 3'b001, 3'b001, 3'b001,
    3'b010, 3'b000, 3'b001, 3'b111, 3'b101, 3'b001, 3'b110
  };

  // random phases: timer length, request count, tick density
  logic [7:0] phase_ticks [NUM_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd255, 8'd3, 8'd24};
  int         phase_items [NUM_PHASES] = '{60, 40, 270, 40, 40, 30};
  int         phase_tick  [NUM_PHASES] = '{80, 70, 100, 95, 60, 85};

  idle_stop_relay_sequencer_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_button_pressed (in_button_pressed),
    .in_pto_active     (in_pto_active),
    .in_tick           (in_tick),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_relay_on      (out_relay_on),
    .out_sequence_step (out_sequence_step),
    .out_pto_phase_out (out_pto_phase_out)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result side: check, then pick next ready (long hold-off on request)
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.relay_on      = out_relay_on;
      seen_result.sequence_step = out_sequence_step;
      seen_result.pto_phase_out = out_pto_phase_out;
      relay_sb.check_result(seen_result);
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("idle_stop_relay_sequencer_top regression: fail");
      $finish;
    end
  end

  // one sample request, with a random idle gap ahead of it
  task send_request(bit btn, bit pto, bit tk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_button_pressed <= btn;
    in_pto_active     <= pto;
    in_tick           <= tk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    relay_sb.note_request(btn, pto, tk);
  endtask

  // timer length write once all results are back and the block is quiet
  task write_pulse_ticks(logic [7:0] value);
    while (relay_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    relay_sb.pulse_ticks = value;
  endtask

  // main sequence
  initial begin
    bit          btn_lvl;
    bit          pto_lvl;
    bit          tk;
    stim_style_t style;
    int          style_left;
    int          r;

    btn_lvl    = 1'b0;
    pto_lvl    = 1'b0;
    style      = STIM_BUTTON;
    style_left = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scripted sequences at the shortest timer
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    write_pulse_ticks(8'd1);
    foreach (scripted[i]) send_request(scripted[i][2], scripted[i][1], scripted[i][0]);
    in_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_pulse_ticks(phase_ticks[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_token++;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (int n = 0; n < phase_items[p]; n++) begin
        // switch stimulus style in bursts
        if (style_left == 0) begin
          r = $urandom_range(9);
          if (r < 4) style = STIM_BUTTON;
          else if (r < 8) style = STIM_PTO;
          else style = STIM_NOISE;
          style_left = 16;
        end
        style_left--;
        // held levels that change now and then, so sequences complete
        case (style)
          STIM_BUTTON: begin
            if ($urandom_range(99) < 20) btn_lvl = ~btn_lvl;
            if ($urandom_range(99) < 3) pto_lvl = ~pto_lvl;
          end
          STIM_PTO: begin
            if ($urandom_range(99) < 3) btn_lvl = ~btn_lvl;
            if ($urandom_range(99) < 15) pto_lvl = ~pto_lvl;
          end
          default: begin
            btn_lvl = $urandom_range(1);
            pto_lvl = $urandom_range(1);
          end
        endcase
        tk = ($urandom_range(99) < phase_tick[p]);
        send_request(btn_lvl, pto_lvl, tk);
      end
      in_valid <= 1'b0;
    end

    // drain
    while (relay_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (relay_sb.pending() != 0)
      relay_sb.report_mismatch($sformatf("%0d results never arrived", relay_sb.pending()));

    $display("covered %0d sample requests: button and pto runs, timer lengths 1 to 256",
             relay_sb.accepted);
    $display("%0d results compared under idle, stall and hold-off traffic, %0d mismatches",
             relay_sb.checked, relay_sb.mismatches);
    if (relay_sb.mismatches == 0) begin
      $display("idle_stop_relay_sequencer_top regression: pass");
    end else begin
      $display("idle_stop_relay_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/isrs_pkg.sv
hdl/idle_stop_relay_sequencer_top.sv
tb/tb_idle_stop_relay_sequencer_top.sv
